### rtl/core/mono_canvas_line_square_drawer_core_macros.svh
// ---------------------------------------------------------------------------
// Canvas drawer assertion macros
// Concurrent assertion wrappers, empty when SYNTHESIS is defined.
// ---------------------------------------------------------------------------
`ifndef MONO_CANVAS_LINE_SQUARE_DRAWER_CORE_MACROS_SVH
`define MONO_CANVAS_LINE_SQUARE_DRAWER_CORE_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset, sampled on clock
`define MCSD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// checked at every edge, reset included
`define MCSD_ASSERT_ALWAYS(label, prop, msg) \
   label: assert property (@(posedge clock) prop) else $error(msg);
`else
`define MCSD_ASSERT(label, prop, msg)
`define MCSD_ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

### rtl/core/mcsd_pkg.sv
// ---------------------------------------------------------------------------
// Canvas drawer package
// Shared types, constants and the page-layout address function.
// ---------------------------------------------------------------------------
package mcsd_pkg;

   localparam int DEF_CANVAS_WIDTH  = 128;
   localparam int DEF_CANVAS_HEIGHT = 32;

   // internal column covers any width up to 255, internal row any height up to 64
   localparam int XW         = 8;
   localparam int YW         = 6;
   localparam int ADDR_MAX_W = 11;
   localparam int QUEUE_DEPTH = 2;

   typedef enum logic [2:0] {
      CMD_SET_PIXEL   = 3'd0,
      CMD_CLEAR_PIXEL = 3'd1,
      CMD_DRAW_LINE   = 3'd2,
      CMD_FILL_SQUARE = 3'd3,
      CMD_READ_BYTE   = 3'd4
   } cmd_type;

   typedef enum logic [1:0] {
      OP_ACCESS = 2'd0,
      OP_LINE   = 2'd1,
      OP_SQUARE = 2'd2
   } op_type;

   typedef enum logic [1:0] {
      ACC_NONE = 2'd0,
      ACC_SET  = 2'd1,
      ACC_CLR  = 2'd2,
      ACC_READ = 2'd3
   } acc_type;

   typedef struct packed {
      op_type                  op;
      acc_type                 acc;
      logic [ADDR_MAX_W-1:0]   addr;
      logic [7:0]              mask;
      logic                    status;
      logic                    steep;
      logic                    neg;
      logic [6:0]              p0;
      logic [6:0]              p1;
      logic [6:0]              q0;
      logic [6:0]              da;
      logic [6:0]              db;
      logic [XW-1:0]           x0;
      logic [XW-1:0]           x1;
      logic [YW-1:0]           y0;
      logic [YW-1:0]           y1;
   } job_type;

   typedef struct packed {
      logic full;
      logic empty;
   } q_status_type;

   function automatic logic [ADDR_MAX_W-1:0] byte_addr(input logic [2:0]    page,
                                                       input logic [XW-1:0] col,
                                                       input logic [XW-1:0] w);
      return ADDR_MAX_W'(page) * ADDR_MAX_W'(w) + ADDR_MAX_W'(col);
   endfunction

endpackage

### rtl/core/mcsd_ram.sv
// ---------------------------------------------------------------------------
// Canvas drawer RAM
// Generic single write port, single read port RAM with registered read.
// ---------------------------------------------------------------------------
module mcsd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 512
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/core/mcsd_front.sv
// ---------------------------------------------------------------------------
// Canvas drawer front end
// Accepts commands, holds one, and classifies it into a job for the queue.
// ---------------------------------------------------------------------------
`include "mono_canvas_line_square_drawer_core_macros.svh"

module mcsd_front import mcsd_pkg::*; #(
   parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  logic [2:0]   req_command,
   input  logic [6:0]   req_x_start,
   input  logic [4:0]   req_y_start,
   input  logic [6:0]   req_x_end,
   input  logic [4:0]   req_y_end,
   input  logic [5:0]   req_square_size,
   input  logic [8:0]   req_byte_index,
   input  logic         clear_active,
   input  q_status_type q_status,
   output logic         q_push,
   output job_type      q_job
);

   localparam int PAGES = (CANVAS_HEIGHT + 7) / 8;
   localparam int DEPTH = CANVAS_WIDTH * PAGES;
   localparam logic [XW-1:0]         WIDTH_X  = XW'(CANVAS_WIDTH);
   localparam logic [YW:0]           HEIGHT_Y = (YW+1)'(CANVAS_HEIGHT);
   localparam logic [ADDR_MAX_W-1:0] DEPTH_A  = ADDR_MAX_W'(DEPTH);

   logic       hold_valid_ff, hold_valid_in;
   cmd_type    hold_command_ff;
   logic [6:0] hold_x_start_ff;
   logic [4:0] hold_y_start_ff;
   logic [6:0] hold_x_end_ff;
   logic [4:0] hold_y_end_ff;
   logic [5:0] hold_size_ff;
   logic [8:0] hold_index_ff;

   logic       accept;
   logic       pix_inb;
   logic [XW-1:0] sq_x_sum;
   logic [YW:0]   sq_y_sum;
   logic       sq_reject;
   logic [6:0] da_x, db_y, ma0, ma1, mi0, mi1, p0, p1, q0, q1;
   logic       steep, swap;

   assign busy   = clear_active || (hold_valid_ff && q_status.full);
   assign accept = start && !busy;
   assign q_push = hold_valid_ff && !q_status.full;

   always_comb begin
      hold_valid_in = hold_valid_ff;
      if (accept) begin
         hold_valid_in = 1'b1;
      end else if (q_push) begin
         hold_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
      end else begin
         hold_valid_ff <= hold_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         hold_command_ff <= cmd_type'(req_command);
         hold_x_start_ff <= req_x_start;
         hold_y_start_ff <= req_y_start;
         hold_x_end_ff   <= req_x_end;
         hold_y_end_ff   <= req_y_end;
         hold_size_ff    <= req_square_size;
         hold_index_ff   <= req_byte_index;
      end
   end

   assign pix_inb = ({1'b0, hold_x_start_ff} < WIDTH_X) &&
                    ({2'b0, hold_y_start_ff} < HEIGHT_Y);

   assign sq_x_sum  = {1'b0, hold_x_start_ff} + {2'b0, hold_size_ff};
   assign sq_y_sum  = {2'b0, hold_y_start_ff} + {1'b0, hold_size_ff};
   assign sq_reject = (sq_x_sum > WIDTH_X) || (sq_y_sum > HEIGHT_Y);

   // line setup: pick the major axis, order endpoints along it
   always_comb begin
      da_x  = (hold_x_end_ff >= hold_x_start_ff) ? hold_x_end_ff - hold_x_start_ff
                                                 : hold_x_start_ff - hold_x_end_ff;
      db_y  = (hold_y_end_ff >= hold_y_start_ff) ? {2'b0, hold_y_end_ff - hold_y_start_ff}
                                                 : {2'b0, hold_y_start_ff - hold_y_end_ff};
      steep = db_y > da_x;
      ma0   = steep ? {2'b0, hold_y_start_ff} : hold_x_start_ff;
      ma1   = steep ? {2'b0, hold_y_end_ff}   : hold_x_end_ff;
      mi0   = steep ? hold_x_start_ff : {2'b0, hold_y_start_ff};
      mi1   = steep ? hold_x_end_ff   : {2'b0, hold_y_end_ff};
      swap  = ma0 > ma1;
      p0    = swap ? ma1 : ma0;
      p1    = swap ? ma0 : ma1;
      q0    = swap ? mi1 : mi0;
      q1    = swap ? mi0 : mi1;
   end

   always_comb begin
      q_job        = '0;
      q_job.op     = OP_ACCESS;
      q_job.acc    = ACC_NONE;
      q_job.steep  = steep;
      q_job.neg    = !(q1 > q0);
      q_job.p0     = p0;
      q_job.p1     = p1;
      q_job.q0     = q0;
      q_job.da     = steep ? db_y : da_x;
      q_job.db     = steep ? da_x : db_y;
      q_job.x0     = {1'b0, hold_x_start_ff};
      q_job.x1     = sq_x_sum - XW'(1);
      q_job.y0     = {1'b0, hold_y_start_ff};
      q_job.y1     = YW'(sq_y_sum - (YW+1)'(1));
      q_job.mask   = 8'b1 << hold_y_start_ff[2:0];
      q_job.addr   = byte_addr({1'b0, hold_y_start_ff[4:3]}, {1'b0, hold_x_start_ff},
                               WIDTH_X);
      unique case (hold_command_ff)
         CMD_SET_PIXEL: begin
            if (pix_inb) begin
               q_job.acc = ACC_SET;
            end
         end
         CMD_CLEAR_PIXEL: begin
            if (pix_inb) begin
               q_job.acc = ACC_CLR;
            end
         end
         CMD_DRAW_LINE: begin
            q_job.op = OP_LINE;
         end
         CMD_FILL_SQUARE: begin
            if (sq_reject) begin
               q_job.status = 1'b1;
            end else if (hold_size_ff != '0) begin
               q_job.op = OP_SQUARE;
            end
         end
         CMD_READ_BYTE: begin
            q_job.addr = ADDR_MAX_W'(hold_index_ff);
            if (ADDR_MAX_W'(hold_index_ff) < DEPTH_A) begin
               q_job.acc = ACC_READ;
            end
         end
         default: begin
            q_job.acc = ACC_NONE;
         end
      endcase
   end

   // a held command must drain in the same cycle a new one lands on it
   `MCSD_ASSERT(a_front_no_overwrite, (accept && hold_valid_ff) |-> q_push, "held command overwritten")

endmodule

### rtl/core/mcsd_queue.sv
// ---------------------------------------------------------------------------
// Canvas drawer job queue
// Short FIFO of classified jobs between the front end and the draw engine.
// ---------------------------------------------------------------------------
`include "mono_canvas_line_square_drawer_core_macros.svh"

module mcsd_queue import mcsd_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  job_type      push_job,
   input  logic         pop,
   output job_type      head_job,
   output q_status_type status
);

   // depth is a power of two so the pointers wrap on their own
   localparam int PW = $clog2(QUEUE_DEPTH);

   job_type       entry_ff [QUEUE_DEPTH];
   logic [PW-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [PW:0]   count_ff, count_in;

   assign status.full  = (count_ff == (PW+1)'(QUEUE_DEPTH));
   assign status.empty = (count_ff == '0);
   assign head_job     = entry_ff[rd_ptr_ff];

   always_comb begin
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + (PW+1)'(1);
      end else if (pop && !push) begin
         count_in = count_ff - (PW+1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         count_ff <= count_in;
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + PW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

   `MCSD_ASSERT(a_queue_no_overflow, push |-> !status.full, "push into full job queue")
   `MCSD_ASSERT(a_queue_no_underflow, pop |-> !status.empty, "pop from empty job queue")

endmodule

### rtl/core/mcsd_back.sv
// ---------------------------------------------------------------------------
// Canvas drawer engine
// Clears the canvas after reset, then carries out queued jobs as a stream of
// byte read-modify-writes, one per cycle, and strobes one result per job.
// ---------------------------------------------------------------------------
`include "mono_canvas_line_square_drawer_core_macros.svh"

module mcsd_back import mcsd_pkg::*; #(
   parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
   input  logic         clock,
   input  logic         reset,
   input  job_type      q_job,
   input  q_status_type q_status,
   output logic         q_pop,
   output logic         clear_active,
   output logic         rsp_strobe,
   output logic [7:0]   rsp_read_data,
   output logic         rsp_status
);

   localparam int PAGES = (CANVAS_HEIGHT + 7) / 8;
   localparam int DEPTH = CANVAS_WIDTH * PAGES;
   localparam int AW    = $clog2(DEPTH);
   localparam logic [XW-1:0] WIDTH_X  = XW'(CANVAS_WIDTH);
   localparam logic [YW:0]   HEIGHT_Y = (YW+1)'(CANVAS_HEIGHT);

   typedef enum logic [3:0] {
      ST_CLEAR  = 4'b0001,
      ST_IDLE   = 4'b0010,
      ST_LINE   = 4'b0100,
      ST_SQUARE = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [AW-1:0]  clr_addr_ff;

   // line walker
   logic [6:0]        p_ff, p_in, q_ff, q_in, p1_ff, p1_in, da_ff, da_in, db_ff, db_in;
   logic              steep_ff, steep_in, neg_ff, neg_in;
   logic signed [8:0] err_ff, err_in, err_sub;
   logic [XW-1:0]     ln_x;
   logic [YW:0]       ln_y;
   logic              ln_inb;

   // square walker
   logic [XW-1:0] col_ff, col_in, col_last_ff, col_last_in;
   logic [2:0]    pg_ff, pg_in, pg_first_ff, pg_first_in, pg_last_ff, pg_last_in;
   logic [YW-1:0] ylo_ff, ylo_in, yhi_ff, yhi_in;
   logic [7:0]    sq_mask;
   logic [YW-1:0] sq_row;

   // issue stage
   logic                  iss_valid, iss_last, iss_status;
   logic [ADDR_MAX_W-1:0] iss_addr;
   logic [7:0]            iss_mask;
   acc_type               iss_acc;

   // modify stage
   logic          s2_valid_ff, s2_last_ff, s2_status_ff;
   logic [AW-1:0] s2_addr_ff;
   logic [7:0]    s2_mask_ff;
   acc_type       s2_acc_ff;
   logic [7:0]    base, new_data, ram_rd_data;
   logic          s2_we;

   // last write, for bypass of the RAM's read-before-write
   logic          lw_valid_ff;
   logic [AW-1:0] lw_addr_ff;
   logic [7:0]    lw_data_ff;

   logic          ram_we;
   logic [AW-1:0] ram_wa;
   logic [7:0]    ram_wd;

   assign clear_active = (state_ff == ST_CLEAR);

   always_comb begin
      ln_x   = steep_ff ? {1'b0, q_ff} : {1'b0, p_ff};
      ln_y   = steep_ff ? p_ff : q_ff;
      ln_inb = (ln_x < WIDTH_X) && (ln_y < HEIGHT_Y);
      err_sub = err_ff - $signed({2'b0, db_ff});
   end

   always_comb begin
      for (int b = 0; b < 8; b++) begin
         sq_row     = {pg_ff, 3'(b)};
         sq_mask[b] = (sq_row >= ylo_ff) && (sq_row <= yhi_ff);
      end
   end

   always_comb begin
      state_in    = state_ff;
      q_pop       = 1'b0;
      iss_valid   = 1'b0;
      iss_addr    = '0;
      iss_mask    = '0;
      iss_acc     = ACC_NONE;
      iss_last    = 1'b0;
      iss_status  = 1'b0;
      p_in        = p_ff;
      q_in        = q_ff;
      p1_in       = p1_ff;
      da_in       = da_ff;
      db_in       = db_ff;
      steep_in    = steep_ff;
      neg_in      = neg_ff;
      err_in      = err_ff;
      col_in      = col_ff;
      col_last_in = col_last_ff;
      pg_in       = pg_ff;
      pg_first_in = pg_first_ff;
      pg_last_in  = pg_last_ff;
      ylo_in      = ylo_ff;
      yhi_in      = yhi_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (!q_status.empty) begin
               q_pop = 1'b1;
               unique case (q_job.op)
                  OP_ACCESS: begin
                     iss_valid  = 1'b1;
                     iss_addr   = q_job.addr;
                     iss_mask   = q_job.mask;
                     iss_acc    = q_job.acc;
                     iss_last   = 1'b1;
                     iss_status = q_job.status;
                  end
                  OP_LINE: begin
                     p_in     = q_job.p0;
                     q_in     = q_job.q0;
                     p1_in    = q_job.p1;
                     da_in    = q_job.da;
                     db_in    = q_job.db;
                     steep_in = q_job.steep;
                     neg_in   = q_job.neg;
                     err_in   = $signed({3'b0, q_job.da[6:1]});
                     state_in = ST_LINE;
                  end
                  OP_SQUARE: begin
                     col_in      = q_job.x0;
                     col_last_in = q_job.x1;
                     pg_in       = q_job.y0[5:3];
                     pg_first_in = q_job.y0[5:3];
                     pg_last_in  = q_job.y1[5:3];
                     ylo_in      = q_job.y0;
                     yhi_in      = q_job.y1;
                     state_in    = ST_SQUARE;
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end
         end
         ST_LINE: begin
            iss_valid = 1'b1;
            iss_addr  = byte_addr(ln_y[5:3], ln_x, WIDTH_X);
            iss_mask  = 8'b1 << ln_y[2:0];
            iss_acc   = ln_inb ? ACC_SET : ACC_NONE;
            iss_last  = (p_ff == p1_ff);
            p_in      = p_ff + 7'd1;
            err_in    = err_sub;
            if (err_sub < 0) begin
               q_in   = neg_ff ? q_ff - 7'd1 : q_ff + 7'd1;
               err_in = err_sub + $signed({2'b0, da_ff});
            end
            if (iss_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_SQUARE: begin
            iss_valid = 1'b1;
            iss_addr  = byte_addr(pg_ff, col_ff, WIDTH_X);
            iss_mask  = sq_mask;
            iss_acc   = ACC_SET;
            iss_last  = (col_ff == col_last_ff) && (pg_ff == pg_last_ff);
            // walk the pages of a column, then step to the next column
            if (pg_ff == pg_last_ff) begin
               pg_in  = pg_first_ff;
               col_in = col_ff + XW'(1);
            end else begin
               pg_in = pg_ff + 3'd1;
            end
            if (iss_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         s2_valid_ff <= 1'b0;
         lw_valid_ff <= 1'b0;
      end else begin
         state_ff    <= state_in;
         s2_valid_ff <= iss_valid;
         lw_valid_ff <= s2_we;
         if (state_ff == ST_CLEAR) begin
            clr_addr_ff <= clr_addr_ff + AW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      p_ff         <= p_in;
      q_ff         <= q_in;
      p1_ff        <= p1_in;
      da_ff        <= da_in;
      db_ff        <= db_in;
      steep_ff     <= steep_in;
      neg_ff       <= neg_in;
      err_ff       <= err_in;
      col_ff       <= col_in;
      col_last_ff  <= col_last_in;
      pg_ff        <= pg_in;
      pg_first_ff  <= pg_first_in;
      pg_last_ff   <= pg_last_in;
      ylo_ff       <= ylo_in;
      yhi_ff       <= yhi_in;
      s2_addr_ff   <= AW'(iss_addr);
      s2_mask_ff   <= iss_mask;
      s2_acc_ff    <= iss_acc;
      s2_last_ff   <= iss_last;
      s2_status_ff <= iss_status;
      lw_addr_ff   <= s2_addr_ff;
      lw_data_ff   <= new_data;
   end

   // take the byte written last cycle when it is the one just read
   assign base = (lw_valid_ff && (lw_addr_ff == s2_addr_ff)) ? lw_data_ff : ram_rd_data;

   always_comb begin
      unique case (s2_acc_ff) inside
         ACC_SET:            new_data = base | s2_mask_ff;
         ACC_CLR:            new_data = base & ~s2_mask_ff;
         ACC_NONE, ACC_READ: new_data = base;
         default:            new_data = base;
      endcase
   end

   assign s2_we = s2_valid_ff && ((s2_acc_ff == ACC_SET) || (s2_acc_ff == ACC_CLR));

   assign ram_we = clear_active || s2_we;
   assign ram_wa = clear_active ? clr_addr_ff : s2_addr_ff;
   assign ram_wd = clear_active ? 8'h00 : new_data;

   mcsd_ram #(
      .WIDTH (8),
      .DEPTH (DEPTH)
   ) u_canvas (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_wa),
      .wr_data (ram_wd),
      .rd_addr (AW'(iss_addr)),
      .rd_data (ram_rd_data)
   );

   assign rsp_strobe    = s2_valid_ff && s2_last_ff;
   assign rsp_read_data = (rsp_strobe && (s2_acc_ff == ACC_READ)) ? base : 8'h00;
   assign rsp_status    = rsp_strobe && s2_status_ff;

   `MCSD_ASSERT_ALWAYS(a_back_reset_clears, reset |=> (state_ff == ST_CLEAR), "no clear pass after reset")
   `MCSD_ASSERT(a_back_pop_idle, q_pop |-> (state_ff == ST_IDLE), "job popped while engine busy")
   `MCSD_ASSERT(a_back_clear_quiet, clear_active |-> !s2_valid_ff, "access in flight during clear pass")
   `MCSD_ASSERT(a_back_write_range, s2_we |-> ({1'b0, s2_addr_ff} < (AW+1)'(DEPTH)), "write beyond canvas")

endmodule

### rtl/core/mono_canvas_line_square_drawer_core.sv
// ---------------------------------------------------------------------------
// Monochrome canvas line and square drawer
// Page-layout one-bit canvas with set/clear pixel, Bresenham line, filled
// square and byte read commands.
//
//   channel   handshake            payload
//   request   start / busy         req_command .. req_byte_index
//   result    rsp_strobe (1 cyc)   rsp_read_data, rsp_status
//
// After reset the canvas RAM is cleared one byte a cycle, all CANVAS_WIDTH *
// ceil(CANVAS_HEIGHT/8) bytes (512 by default), with busy high throughout.
// The engine does one byte read-modify-write per cycle: pixel, read and rejected
// commands take one, a line one per point, a square one per page of each column.
// A command passes the hold register, job queue and modify stage before its
// result is strobed; after the clear, busy rises only when the hold register
// and the two-entry job queue are both full. The receiver cannot stall.
// ---------------------------------------------------------------------------
module mono_canvas_line_square_drawer_core import mcsd_pkg::*; #(
   parameter int CANVAS_WIDTH  = DEF_CANVAS_WIDTH,
   parameter int CANVAS_HEIGHT = DEF_CANVAS_HEIGHT
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       start,
   output logic       busy,
   input  logic [2:0] req_command,
   input  logic [6:0] req_x_start,
   input  logic [4:0] req_y_start,
   input  logic [6:0] req_x_end,
   input  logic [4:0] req_y_end,
   input  logic [5:0] req_square_size,
   input  logic [8:0] req_byte_index,
   output logic       rsp_strobe,
   output logic [7:0] rsp_read_data,
   output logic       rsp_status
);

   logic         clear_active;
   logic         q_push, q_pop;
   job_type      push_job, head_job;
   q_status_type q_status;

   mcsd_front #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_square_size (req_square_size),
      .req_byte_index  (req_byte_index),
      .clear_active    (clear_active),
      .q_status        (q_status),
      .q_push          (q_push),
      .q_job           (push_job)
   );

   mcsd_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (q_push),
      .push_job (push_job),
      .pop      (q_pop),
      .head_job (head_job),
      .status   (q_status)
   );

   mcsd_back #(
      .CANVAS_WIDTH  (CANVAS_WIDTH),
      .CANVAS_HEIGHT (CANVAS_HEIGHT)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .q_job         (head_job),
      .q_status      (q_status),
      .q_pop         (q_pop),
      .clear_active  (clear_active),
      .rsp_strobe    (rsp_strobe),
      .rsp_read_data (rsp_read_data),
      .rsp_status    (rsp_status)
   );

endmodule

### tb/sv/mono_canvas_line_square_drawer_core_test.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Canvas drawer core test
// Drives pixel, line, square, read and spare commands through the start/busy
// port with bursty timing, keeps a shadow canvas to predict every response,
// and compares each strobed response against the oldest prediction.
// ---------------------------------------------------------------------------
module mono_canvas_line_square_drawer_core_test;
   import mcsd_pkg::*;

   localparam int CANVAS_COLS  = DEF_CANVAS_WIDTH;
   localparam int CANVAS_ROWS  = DEF_CANVAS_HEIGHT;
   localparam int CANVAS_BYTES = CANVAS_COLS * ((CANVAS_ROWS + 7) / 8);
   localparam int RANDOM_ITEMS = 2000;
   localparam int DRAIN_CYCLES = 40;
   localparam int REPORT_LIMIT = 10;

   // commands with no effect
   localparam logic [2:0] CMD_SPARE_FIRST = 3'd5;
   localparam logic [2:0] CMD_SPARE_LAST  = 3'd7;

   typedef struct {
      logic [2:0] command;
      logic [6:0] x_start;
      logic [4:0] y_start;
      logic [6:0] x_end;
      logic [4:0] y_end;
      logic [5:0] square_size;
      logic [8:0] byte_index;
   } draw_cmd_type;

   typedef struct {
      logic [7:0] read_data;
      logic       status;
   } canvas_reply_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       start = 1'b0;
   logic       busy;
   logic [2:0] req_command     = '0;
   logic [6:0] req_x_start     = '0;
   logic [4:0] req_y_start     = '0;
   logic [6:0] req_x_end       = '0;
   logic [4:0] req_y_end       = '0;
   logic [5:0] req_square_size = '0;
   logic [8:0] req_byte_index  = '0;
   logic       rsp_strobe;
   logic [7:0] rsp_read_data;
   logic       rsp_status;

   draw_cmd_type     cmd_q[$];
   canvas_reply_type reply_q[$];
   logic [7:0]       canvas_shadow [CANVAS_BYTES];
   int               error_count = 0;
   int               burst_left  = 1;
   int               gap_left    = 0;
   int               recent_x    = 0;
   int               recent_y    = 0;
   canvas_reply_type got_reply;
   canvas_reply_type want_reply;

   mono_canvas_line_square_drawer_core dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_command     (req_command),
      .req_x_start     (req_x_start),
      .req_y_start     (req_y_start),
      .req_x_end       (req_x_end),
      .req_y_end       (req_y_end),
      .req_square_size (req_square_size),
      .req_byte_index  (req_byte_index),
      .rsp_strobe      (rsp_strobe),
      .rsp_read_data   (rsp_read_data),
      .rsp_status      (rsp_status)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   // ---------------- shadow canvas ----------------

   function automatic void paint_pixel(int x, int y, bit on);
      int idx;
      if (x < 0 || y < 0 || x >= CANVAS_COLS || y >= CANVAS_ROWS) return;
      idx = (y / 8) * CANVAS_COLS + x;
      canvas_shadow[idx][y % 8] = on;
   endfunction

   function automatic void trace_line(int ax, int ay, int bx, int by);
      int da, db, p0, q0, p1, q1, t, err, stp, q;
      bit steep;
      da = (ax > bx) ? ax - bx : bx - ax;
      db = (ay > by) ? ay - by : by - ay;
      steep = db > da;
      if (steep) begin
         t = da; da = db; db = t;
         p0 = ay; q0 = ax; p1 = by; q1 = bx;
      end else begin
         p0 = ax; q0 = ay; p1 = bx; q1 = by;
      end
      // walk the major axis from the lower endpoint
      if (p0 > p1) begin
         t = p0; p0 = p1; p1 = t;
         t = q0; q0 = q1; q1 = t;
      end
      err = da >>> 1;
      stp = (q1 > q0) ? 1 : -1;
      q = q0;
      for (int p = p0; p <= p1; p++) begin
         if (steep) paint_pixel(q, p, 1'b1);
         else paint_pixel(p, q, 1'b1);
         err -= db;
         if (err < 0) begin
            q += stp;
            err += da;
         end
      end
   endfunction

   function automatic canvas_reply_type predict_reply(draw_cmd_type c);
      canvas_reply_type r;
      int xs, ys, sz;
      r.read_data = '0;
      r.status = 1'b0;
      xs = int'(c.x_start);
      ys = int'(c.y_start);
      sz = int'(c.square_size);
      case (c.command)
         CMD_SET_PIXEL: begin
            paint_pixel(xs, ys, 1'b1);
         end
         CMD_CLEAR_PIXEL: begin
            paint_pixel(xs, ys, 1'b0);
         end
         CMD_DRAW_LINE: begin
            trace_line(xs, ys, int'(c.x_end), int'(c.y_end));
         end
         CMD_FILL_SQUARE: begin
            if (xs + sz > CANVAS_COLS || ys + sz > CANVAS_ROWS) begin
               r.status = 1'b1;
            end else begin
               for (int i = xs; i < xs + sz; i++)
                  for (int j = ys; j < ys + sz; j++)
                     paint_pixel(i, j, 1'b1);
            end
         end
         CMD_READ_BYTE: begin
            if (int'(c.byte_index) < CANVAS_BYTES) r.read_data = canvas_shadow[c.byte_index];
         end
         default: begin
         end
      endcase
      return r;
   endfunction

   // ---------------- stimulus ----------------

   function automatic void queue_command(logic [2:0] cmd, int xs, int ys, int xe, int ye,
                                         int sz, int idx);
      draw_cmd_type c;
      c.command     = cmd;
      c.x_start     = 7'(xs);
      c.y_start     = 5'(ys);
      c.x_end       = 7'(xe);
      c.y_end       = 5'(ye);
      c.square_size = 6'(sz);
      c.byte_index  = 9'(idx);
      cmd_q.push_back(c);
   endfunction

   function automatic int clamp(int v, int hi);
      if (v < 0) return 0;
      if (v > hi) return hi;
      return v;
   endfunction

   function automatic draw_cmd_type random_command();
      draw_cmd_type c;
      int pick;
      c.command     = 3'($urandom_range(0, 7));
      c.x_start     = 7'($urandom);
      c.y_start     = 5'($urandom);
      c.x_end       = 7'($urandom);
      c.y_end       = 5'($urandom);
      c.square_size = 6'($urandom);
      c.byte_index  = 9'($urandom);
      pick = int'($urandom_range(0, 99));
      if (pick < 15) begin
         c.command = CMD_SET_PIXEL;
      end else if (pick < 40) begin
         c.command = CMD_CLEAR_PIXEL;
      end else if (pick < 55) begin
         c.command = CMD_DRAW_LINE;
      end else if (pick < 68) begin
         c.command = CMD_FILL_SQUARE;
      end else if (pick < 95) begin
         c.command = CMD_READ_BYTE;
      end else begin
         c.command = 3'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
      end
      case (c.command)
         CMD_SET_PIXEL, CMD_CLEAR_PIXEL: begin
            // stay near recent drawing so clears hit lit pixels
            if ($urandom_range(0, 1)) begin
               c.x_start = 7'(clamp(recent_x + int'($urandom_range(0, 6)) - 3,
                                    CANVAS_COLS - 1));
               c.y_start = 5'(clamp(recent_y + int'($urandom_range(0, 6)) - 3,
                                    CANVAS_ROWS - 1));
            end
         end
         CMD_DRAW_LINE: begin
            if ($urandom_range(0, 4) != 0) begin
               c.x_end = 7'(clamp(int'(c.x_start) + int'($urandom_range(0, 16)) - 8,
                                  CANVAS_COLS - 1));
               c.y_end = 5'(clamp(int'(c.y_start) + int'($urandom_range(0, 16)) - 8,
                                  CANVAS_ROWS - 1));
            end
         end
         CMD_FILL_SQUARE: begin
            pick = int'($urandom_range(0, 9));
            if (pick < 7) c.square_size = 6'($urandom_range(0, 5));
            else if (pick < 9) c.square_size = 6'($urandom_range(0, CANVAS_ROWS));
         end
         CMD_READ_BYTE: begin
            if ($urandom_range(0, 1))
               c.byte_index = 9'((recent_y / 8) * CANVAS_COLS + recent_x);
         end
         default: begin
         end
      endcase
      if (c.command inside {CMD_SET_PIXEL, CMD_CLEAR_PIXEL, CMD_DRAW_LINE,
                            CMD_FILL_SQUARE}) begin
         recent_x = int'(c.x_start);
         recent_y = int'(c.y_start);
      end
      return c;
   endfunction

   // ---------------- driver ----------------

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            reply_q.push_back(predict_reply(cmd_q[0]));
            void'(cmd_q.pop_front());
            burst_left--;
            if (burst_left <= 0) begin
               burst_left = ($urandom_range(0, 9) == 0) ? 100 : int'($urandom_range(1, 12));
               gap_left = ($urandom_range(0, 2) == 0) ? 0 : int'($urandom_range(1, 15));
            end
         end
         // hold a transaction that busy is still refusing
         if (start && busy) begin
         end else if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (cmd_q.size() > 0) begin
            start           <= 1'b1;
            req_command     <= cmd_q[0].command;
            req_x_start     <= cmd_q[0].x_start;
            req_y_start     <= cmd_q[0].y_start;
            req_x_end       <= cmd_q[0].x_end;
            req_y_end       <= cmd_q[0].y_end;
            req_square_size <= cmd_q[0].square_size;
            req_byte_index  <= cmd_q[0].byte_index;
         end else begin
            start <= 1'b0;
         end
      end
   end

   // ---------------- monitor ----------------

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         got_reply.read_data = rsp_read_data;
         got_reply.status    = rsp_status;
         if (reply_q.size() == 0) begin
            error_count++;
            if (error_count <= REPORT_LIMIT)
               $display("unexpected response: read_data %h status %b",
                        got_reply.read_data, got_reply.status);
         end else begin
            want_reply = reply_q.pop_front();
            if (got_reply.read_data !== want_reply.read_data ||
                got_reply.status !== want_reply.status) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("response mismatch: read_data exp %h got %h, status exp %b got %b",
                           want_reply.read_data, got_reply.read_data,
                           want_reply.status, got_reply.status);
            end
         end
      end
   end

   // ---------------- sequence ----------------

   initial begin
      for (int i = 0; i < CANVAS_BYTES; i++) canvas_shadow[i] = '0;

      // corners of the canvas
      queue_command(CMD_SET_PIXEL, 0, 0, 0, 0, 0, 0);
      queue_command(CMD_SET_PIXEL, 127, 31, 127, 31, 63, 511);
      queue_command(CMD_READ_BYTE, 0, 0, 0, 0, 0, 0);
      queue_command(CMD_READ_BYTE, 127, 31, 127, 31, 63, 511);
      queue_command(CMD_CLEAR_PIXEL, 127, 31, 0, 0, 0, 0);
      queue_command(CMD_READ_BYTE, 0, 0, 0, 0, 0, 511);
      // clear keeps the neighbor bits of the byte
      queue_command(CMD_SET_PIXEL, 5, 3, 0, 0, 0, 0);
      queue_command(CMD_SET_PIXEL, 5, 4, 0, 0, 0, 0);
      queue_command(CMD_CLEAR_PIXEL, 5, 3, 0, 0, 0, 0);
      queue_command(CMD_READ_BYTE, 0, 0, 0, 0, 0, 5);
      // shallow, steep, reversed and single-point lines
      queue_command(CMD_DRAW_LINE, 0, 0, 127, 31, 0, 0);
      queue_command(CMD_DRAW_LINE, 10, 31, 12, 0, 0, 0);
      queue_command(CMD_DRAW_LINE, 127, 0, 0, 31, 0, 0);
      queue_command(CMD_DRAW_LINE, 64, 16, 64, 16, 0, 0);
      queue_command(CMD_DRAW_LINE, 40, 20, 30, 10, 0, 0);
      queue_command(CMD_READ_BYTE, 0, 0, 0, 0, 0, 138);
      // squares: fits at edge, rejected by one, full height, empty, oversize
      queue_command(CMD_FILL_SQUARE, 120, 0, 0, 0, 8, 0);
      queue_command(CMD_FILL_SQUARE, 121, 0, 0, 0, 8, 0);
      queue_command(CMD_FILL_SQUARE, 0, 1, 0, 0, 32, 0);
      queue_command(CMD_FILL_SQUARE, 90, 10, 0, 0, 0, 0);
      queue_command(CMD_FILL_SQUARE, 0, 0, 0, 0, 63, 0);
      queue_command(CMD_FILL_SQUARE, 0, 0, 0, 0, 32, 0);
      queue_command(CMD_READ_BYTE, 0, 0, 0, 0, 0, 383);
      queue_command(CMD_SPARE_LAST, 127, 31, 127, 31, 63, 511);
      queue_command(CMD_SPARE_FIRST, 0, 0, 0, 0, 0, 0);

      for (int i = 0; i < RANDOM_ITEMS; i++) cmd_q.push_back(random_command());

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (cmd_q.size() != 0 || reply_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0) begin
         $display("mono_canvas_line_square_drawer_core_test: done, clean");
      end else begin
         $display("mono_canvas_line_square_drawer_core_test: done, errors");
      end
      $finish;
   end

   initial begin
      #2_500_000;
      $display("mono_canvas_line_square_drawer_core_test: done, errors");
      $finish;
   end

endmodule
